// ----- rtl/ddrh_pkg.sv -----
// Shared types, register indexes and reset values for the differential drive controller.
package ddrh_pkg;

    localparam int unsigned SPEED_W    = 8;
    localparam int unsigned DUTY_W     = 7;
    localparam int unsigned STEP_W     = 7;
    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned CMD_SPD_W  = 11;
    localparam int unsigned SUM_W      = CMD_SPD_W + 1;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_DATA_W   = 24;
    localparam int unsigned M_DATA_W   = 40;

    localparam logic [CFG_ADDR_W-1:0] REG_RAMP_STEP     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RAMP_INTERVAL = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_LIMIT   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND      = 2'd3;

    localparam logic [STEP_W-1:0]     RST_RAMP_STEP     = 7'd5;
    localparam logic [INTERVAL_W-1:0] RST_RAMP_INTERVAL = 16'd100;
    localparam logic [STEP_W-1:0]     RST_SPEED_LIMIT   = 7'd100;
    localparam logic [STEP_W-1:0]     RST_DEADBAND      = 7'd10;

    localparam logic CMD_DRIVE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef struct packed {
        logic [STEP_W-1:0] ramp_step;
        logic [STEP_W-1:0] speed_limit;
        logic [STEP_W-1:0] deadband;
    } t_wheel_cfg;

    typedef struct packed {
        logic load;
        logic ramp;
    } t_wheel_ctl;

endpackage

// ----- rtl/ddrh_wheel.sv -----
// One wheel: target clamp and deadband, slew-limited current speed.
module ddrh_wheel
    import ddrh_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_wheel_cfg                i_cfg,
    input  t_wheel_ctl                i_ctl,
    input  logic signed [SUM_W-1:0]   i_sum,
    output logic signed [SPEED_W-1:0] o_speed
);

    logic signed [SPEED_W-1:0] r_target, n_target;
    logic signed [SPEED_W-1:0] r_current, n_current;

    logic signed [SUM_W-1:0]   w_lim;
    logic signed [SUM_W-1:0]   w_clip;
    logic        [SUM_W-1:0]   w_clip_abs;
    logic signed [SPEED_W-1:0] w_new_target;

    logic signed [SPEED_W:0]   w_err;
    logic        [SPEED_W:0]   w_err_abs;
    logic        [SPEED_W:0]   w_mag;
    logic signed [SPEED_W-1:0] w_slewed;

    always_comb begin
        w_lim = signed'({{(SUM_W-STEP_W){1'b0}}, i_cfg.speed_limit});
        w_clip = i_sum;
        if (i_sum > w_lim) begin
            w_clip = w_lim;
        end else if (i_sum < -w_lim) begin
            w_clip = -w_lim;
        end
        w_clip_abs = w_clip[SUM_W-1] ? unsigned'(-w_clip) : unsigned'(w_clip);
        if (w_clip_abs < {{(SUM_W-STEP_W){1'b0}}, i_cfg.deadband}) begin
            w_new_target = '0;
        end else begin
            w_new_target = w_clip[SPEED_W-1:0];
        end
    end

    always_comb begin
        w_err = {r_target[SPEED_W-1], r_target} - {r_current[SPEED_W-1], r_current};
        w_err_abs = w_err[SPEED_W] ? unsigned'(-w_err) : unsigned'(w_err);
        w_mag = (w_err_abs > {{(SPEED_W+1-STEP_W){1'b0}}, i_cfg.ramp_step})
              ? {{(SPEED_W+1-STEP_W){1'b0}}, i_cfg.ramp_step} : w_err_abs;
        if (!w_err[SPEED_W] && (w_err != '0)) begin
            w_slewed = r_current + signed'(w_mag[SPEED_W-1:0]);
        end else begin
            w_slewed = r_current - signed'(w_mag[SPEED_W-1:0]);
        end
    end

    assign n_target  = i_ctl.load ? w_new_target : r_target;
    assign n_current = i_ctl.ramp ? w_slewed : r_current;
    assign o_speed   = n_current;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= '0;
            r_current <= '0;
        end else begin
            r_target  <= n_target;
            r_current <= n_current;
        end
    end

endmodule

// ----- rtl/diff_drive_ramped_hbridge.sv -----
// Top level of the two-wheel H-bridge speed controller with ramped speed changes.
//
//  channel   dir  handshake                   payload
//  s_axis    in   tvalid / tready             tuser: command; tdata: linear, angular
//  m_axis    out  tvalid / tready             tdata: speeds, duties, direction bits
//  cfg       in   wen (no wait, no readback)  addr: register index; wdata: value
//
//  One transaction per cycle while input ready is high: targets, tick count and wheel
//  speeds update in the accepting cycle and the result is registered.
//  A two-entry output stage (output register plus skid register) keeps input ready
//  high while a single result waits; ready drops only when both entries are full.
//  Synchronous active-low reset clears speeds, targets, tick count and output state
//  and loads the register defaults.
module diff_drive_ramped_hbridge
    import ddrh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [10:0] linear_speed, [21:11] angular_speed, [23:22] zero
    input  logic [S_DATA_W-1:0]   i_s_axis_tdata,
    // [0] command
    input  logic [0:0]            i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [7:0] right_speed, [15:8] left_speed, [22:16] right_duty, [29:23] left_duty,
    // [30] right_forward, [31] right_reverse, [32] left_forward, [33] left_reverse,
    // [39:34] zero
    output logic [M_DATA_W-1:0]   o_m_axis_tdata,
    input  logic                  i_cfg_wen,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [STEP_W-1:0]     r_ramp_step;
    logic [INTERVAL_W-1:0] r_ramp_interval;
    logic [STEP_W-1:0]     r_speed_limit;
    logic [STEP_W-1:0]     r_deadband;
    logic [INTERVAL_W-1:0] r_elapsed, n_elapsed;

    logic                  r_out_valid, r_skid_valid;
    logic [M_DATA_W-1:0]   r_out_data, r_skid_data;

    logic                  w_accept, w_tick, w_expire, w_pop;
    logic [INTERVAL_W-1:0] w_elapsed_inc;
    logic signed [CMD_SPD_W-1:0] w_lin, w_ang;
    logic signed [SUM_W-1:0]     w_right_sum, w_left_sum;
    t_wheel_cfg            w_cfg;
    t_wheel_ctl            w_ctl;
    logic signed [SPEED_W-1:0] w_right_speed, w_left_speed;
    logic [SPEED_W-1:0]    w_right_abs, w_left_abs;
    logic [M_DATA_W-1:0]   w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_step     <= RST_RAMP_STEP;
            r_ramp_interval <= RST_RAMP_INTERVAL;
            r_speed_limit   <= RST_SPEED_LIMIT;
            r_deadband      <= RST_DEADBAND;
        end else if (i_cfg_wen) begin
            case (i_cfg_addr)
                REG_RAMP_STEP:     r_ramp_step     <= i_cfg_wdata[STEP_W-1:0];
                REG_RAMP_INTERVAL: r_ramp_interval <= i_cfg_wdata[INTERVAL_W-1:0];
                REG_SPEED_LIMIT:   r_speed_limit   <= i_cfg_wdata[STEP_W-1:0];
                REG_DEADBAND:      r_deadband      <= i_cfg_wdata[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_s_axis_tready = !r_skid_valid;
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_tick   = w_accept && (i_s_axis_tuser[0] == CMD_TICK);

    assign w_elapsed_inc = (r_elapsed == {INTERVAL_W{1'b1}}) ? r_elapsed : r_elapsed + 1'b1;
    assign w_expire      = w_elapsed_inc > r_ramp_interval;

    always_comb begin
        n_elapsed = r_elapsed;
        if (w_tick) begin
            n_elapsed = w_expire ? '0 : w_elapsed_inc;
        end
    end

    assign w_lin = signed'(i_s_axis_tdata[CMD_SPD_W-1:0]);
    assign w_ang = signed'(i_s_axis_tdata[2*CMD_SPD_W-1:CMD_SPD_W]);
    assign w_right_sum = SUM_W'(w_lin) + SUM_W'(w_ang);
    assign w_left_sum  = SUM_W'(w_lin) - SUM_W'(w_ang);

    assign w_cfg.ramp_step   = r_ramp_step;
    assign w_cfg.speed_limit = r_speed_limit;
    assign w_cfg.deadband    = r_deadband;
    assign w_ctl.load = w_accept && (i_s_axis_tuser[0] == CMD_DRIVE);
    assign w_ctl.ramp = w_tick && w_expire;

    ddrh_wheel u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_ctl   (w_ctl),
        .i_sum   (w_right_sum),
        .o_speed (w_right_speed)
    );

    ddrh_wheel u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_ctl   (w_ctl),
        .i_sum   (w_left_sum),
        .o_speed (w_left_speed)
    );

    assign w_right_abs = w_right_speed[SPEED_W-1] ? unsigned'(-w_right_speed)
                                                  : unsigned'(w_right_speed);
    assign w_left_abs  = w_left_speed[SPEED_W-1] ? unsigned'(-w_left_speed)
                                                 : unsigned'(w_left_speed);

    assign w_result = {
        6'd0,
        w_left_speed[SPEED_W-1],
        (!w_left_speed[SPEED_W-1] && (w_left_speed != '0)),
        w_right_speed[SPEED_W-1],
        (!w_right_speed[SPEED_W-1] && (w_right_speed != '0)),
        w_left_abs[DUTY_W-1:0],
        w_right_abs[DUTY_W-1:0],
        w_left_speed,
        w_right_speed
    };

    assign w_pop = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed    <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_elapsed <= n_elapsed;
            if (w_pop) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_accept;
                end
            end else if (w_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out_data <= r_skid_valid ? r_skid_data : w_result;
        end
        if (!w_pop && w_accept) begin
            r_skid_data <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
